>>> design/psc_pkg.sv
// Package for the pattern subsequence counter.
// Holds the pattern text used by the front part, and the count width and the
// modular add used by the back part. No dependencies.
package psc_pkg;

   localparam int PATTERN_MAX  = 64;
   localparam int CHAR_WIDTH   = 8;
   localparam int COUNT_WIDTH  = 14;
   localparam int POS_WIDTH    = 6;
   localparam int QUEUE_DEPTH  = 4;

   localparam logic [COUNT_WIDTH:0] COUNT_MODULUS = 15'd10000;

   // Pattern letter at a position; positions past the text hold byte zero
   function automatic logic [CHAR_WIDTH-1:0] pattern_char(input logic [POS_WIDTH-1:0] pos);
      logic [CHAR_WIDTH-1:0] letter;
      begin
         unique case (pos)
            6'd0:    letter = 8'h77; // w
            6'd1:    letter = 8'h65; // e
            6'd2:    letter = 8'h6C; // l
            6'd3:    letter = 8'h63; // c
            6'd4:    letter = 8'h6F; // o
            6'd5:    letter = 8'h6D; // m
            6'd6:    letter = 8'h65; // e
            6'd7:    letter = 8'h20; // space
            6'd8:    letter = 8'h74; // t
            6'd9:    letter = 8'h6F; // o
            6'd10:   letter = 8'h20; // space
            6'd11:   letter = 8'h63; // c
            6'd12:   letter = 8'h6F; // o
            6'd13:   letter = 8'h64; // d
            6'd14:   letter = 8'h65; // e
            6'd15:   letter = 8'h20; // space
            6'd16:   letter = 8'h6A; // j
            6'd17:   letter = 8'h61; // a
            6'd18:   letter = 8'h6D; // m
            default: letter = 8'h00;
         endcase
         return letter;
      end
   endfunction

   // Sum of two residues, brought back below the modulus by one subtract
   function automatic logic [COUNT_WIDTH-1:0] mod_add(input logic [COUNT_WIDTH-1:0] a,
                                                      input logic [COUNT_WIDTH-1:0] b);
      logic [COUNT_WIDTH:0] sum;
      begin
         sum = {1'b0, a} + {1'b0, b};
         if (sum >= COUNT_MODULUS) begin
            sum = sum - COUNT_MODULUS;
         end
         return sum[COUNT_WIDTH-1:0];
      end
   endfunction

endpackage

>>> design/psc_front.sv
// Front part of the pattern subsequence counter: takes input words and turns
// each character into a per-position match vector for the queue.
// Depends on psc_pkg.
module psc_front #(
   parameter int PATTERN_LENGTH = 19
) (
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [psc_pkg::CHAR_WIDTH-1:0]   req_character,
   input  logic                             req_end_of_line,
   input  logic                             queue_full,
   output logic                             queue_push,
   output logic [PATTERN_LENGTH:0]          queue_data
);
   import psc_pkg::*;

   logic [PATTERN_LENGTH-1:0] match;

   // Compare the character with every pattern letter at once
   for (genvar j = 0; j < PATTERN_LENGTH; j++) begin : g_match
      assign match[j] = (req_character == pattern_char(POS_WIDTH'(j)));
   end

   // Hold off the source only while the queue has no room
   assign req_stall  = queue_full;
   assign queue_push = req_valid && !queue_full;
   assign queue_data = {req_end_of_line, match};

endmodule

>>> design/psc_queue.sv
// Short FIFO between the front and back parts of the counter.
// Register-based storage, no dependencies beyond psc_pkg.
module psc_queue #(
   parameter int WIDTH = 20,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             full,
   output logic             not_empty,
   output logic [WIDTH-1:0] head_data
);
   import psc_pkg::*;

   localparam int PTR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_WIDTH = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]     store_ff [DEPTH];
   logic [PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_WIDTH'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_data = store_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> design/psc_back.sv
// Back part of the counter: the row of prefix counters, updated in parallel
// from queued match vectors, and the registered result word.
// Depends on psc_pkg.
module psc_back #(
   parameter int PATTERN_LENGTH = 19
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              queue_not_empty,
   input  logic [PATTERN_LENGTH:0]           queue_head,
   output logic                              queue_pop,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [psc_pkg::COUNT_WIDTH-1:0]   rsp_occurrence_count
);
   import psc_pkg::*;

   logic [COUNT_WIDTH-1:0]    counts_ff [PATTERN_LENGTH];
   logic [COUNT_WIDTH-1:0]    counts_in [PATTERN_LENGTH];
   logic [COUNT_WIDTH-1:0]    updated   [PATTERN_LENGTH];
   logic [PATTERN_LENGTH-1:0] match;
   logic                      last;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [COUNT_WIDTH-1:0]    rsp_count_ff, rsp_count_in;

   assign match = queue_head[PATTERN_LENGTH-1:0];
   assign last  = queue_head[PATTERN_LENGTH];

   // Take a word unless it ends a line and the result slot is still blocked
   assign queue_pop = queue_not_empty && (!last || !rsp_valid_ff || !rsp_stall);

   // Per-position update: matching positions add the previous position's old count (position 0 adds one)
   for (genvar j = 0; j < PATTERN_LENGTH; j++) begin : g_pos
      if (j == 0) begin : g_first
         assign updated[j] = match[j] ? mod_add(counts_ff[j], COUNT_WIDTH'(1)) : counts_ff[j];
      end else begin : g_rest
         assign updated[j] = match[j] ? mod_add(counts_ff[j], counts_ff[j-1]) : counts_ff[j];
      end
      // cleared once the line is done
      assign counts_in[j] = (queue_pop && last) ? '0 : (queue_pop ? updated[j] : counts_ff[j]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < PATTERN_LENGTH; k++) begin
            counts_ff[k] <= '0;
         end
      end else begin
         for (int k = 0; k < PATTERN_LENGTH; k++) begin
            counts_ff[k] <= counts_in[k];
         end
      end
   end

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_count_in = rsp_count_ff;
      if (queue_pop && last) begin
         rsp_valid_in = 1'b1;
         rsp_count_in = updated[PATTERN_LENGTH-1];
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_occurrence_count = rsp_count_ff;

`ifndef SYNTH
   // Reported count is always a residue
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_count_ff < COUNT_MODULUS[COUNT_WIDTH-1:0]))
      else $error("result count out of range");

   // After an end of line the last counter is cleared
   a_clear_after_line: assert property (@(posedge clock) disable iff (reset)
      (queue_pop && last) |=> (counts_ff[PATTERN_LENGTH-1] == '0))
      else $error("counters not cleared after end of line");

   // A waiting result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !(queue_pop && last))
      else $error("stalled result overwritten");

   // First counter untouched when nothing is taken from the queue
   a_hold_idle: assert property (@(posedge clock) disable iff (reset)
      !queue_pop |=> $stable(counts_ff[0]))
      else $error("counter changed without a word");
`endif

endmodule

>>> design/pattern_subsequence_counter_core.sv
// Counts, modulo 10000, how often the fixed 19-letter pattern held in psc_pkg occurs as a
// subsequence of a text line given one character word per cycle. Sustained rate
// is one character per cycle while req_stall stays low: all prefix counters
// update in parallel from their old values. The character that ends the line
// passes through the front queue and then the counter row into the registered
// result word; counters then restart from zero for the next line.
// Depends on psc_pkg, psc_front, psc_queue and psc_back.
module pattern_subsequence_counter_core #(
   parameter int PATTERN_LENGTH = 19
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [psc_pkg::CHAR_WIDTH-1:0]    req_character,
   input  logic                              req_end_of_line,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [psc_pkg::COUNT_WIDTH-1:0]   rsp_occurrence_count
);
   import psc_pkg::*;

   logic                    queue_full;
   logic                    queue_push;
   logic [PATTERN_LENGTH:0] queue_data;
   logic                    queue_pop;
   logic                    queue_not_empty;
   logic [PATTERN_LENGTH:0] queue_head;

   // Classify incoming characters
   psc_front #(
      .PATTERN_LENGTH (PATTERN_LENGTH)
   ) u_front (
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_character   (req_character),
      .req_end_of_line (req_end_of_line),
      .queue_full      (queue_full),
      .queue_push      (queue_push),
      .queue_data      (queue_data)
   );

   // Decoupling queue
   psc_queue #(
      .WIDTH (PATTERN_LENGTH + 1),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_data (queue_data),
      .pop       (queue_pop),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .head_data (queue_head)
   );

   // Counter row and result
   psc_back #(
      .PATTERN_LENGTH (PATTERN_LENGTH)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .queue_not_empty      (queue_not_empty),
      .queue_head           (queue_head),
      .queue_pop            (queue_pop),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_occurrence_count (rsp_occurrence_count)
   );

endmodule

>>> tb/pattern_subsequence_counter_core_tb.sv
// Testbench for pattern_subsequence_counter_core: text lines in, one count out per line.
// Keeps its own copy of the prefix counter row, with random idling on both channels.
// Depends on psc_pkg and the counter core.
module pattern_subsequence_counter_core_tb;

   import psc_pkg::*;

   localparam int PATTERN_LEN   = 19;
   localparam int COUNT_MOD     = 10000;
   localparam int TARGET_CHARS  = 1700;
   localparam int CALM_FROM     = 1500;

   // pattern letters, first letter in the top byte
   localparam logic [8*PATTERN_LEN-1:0] PATTERN_TEXT = {
      8'h77, 8'h65, 8'h6C, 8'h63, 8'h6F, 8'h6D, 8'h65, 8'h20, 8'h74, 8'h6F,
      8'h20, 8'h63, 8'h6F, 8'h64, 8'h65, 8'h20, 8'h6A, 8'h61, 8'h6D
   };

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [CHAR_WIDTH-1:0]  req_character = '0;
   logic                   req_end_of_line = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [COUNT_WIDTH-1:0] rsp_occurrence_count;

   int                     idle_level = 0;
   int                     chars_sent = 0;
   int                     lines_sent = 0;
   bit [CHAR_WIDTH-1:0]    line_bytes [$];

   function automatic bit [CHAR_WIDTH-1:0] letter_at(input int pos);
      return PATTERN_TEXT[8*(PATTERN_LEN-1-pos) +: 8];
   endfunction

   // Prefix counter row and the counts still owed by the block
   class line_count_board;
      bit [COUNT_WIDTH-1:0] prefix [PATTERN_LEN];
      bit [COUNT_WIDTH-1:0] owed_counts [$];
      int                   mismatches = 0;
      int                   counts_checked = 0;
      int                   nonzero_counts = 0;

      function void note_character(input bit [CHAR_WIDTH-1:0] ch, input bit eol);
         bit [COUNT_WIDTH-1:0] old [PATTERN_LEN];
         int                   sum;
         old = prefix;
         // every matching position adds its predecessor's old count (position 0 adds one)
         for (int j = 0; j < PATTERN_LEN; j++) begin
            if (letter_at(j) == ch) begin
               sum = int'(old[j]) + ((j == 0) ? 1 : int'(old[j-1]));
               if (sum >= COUNT_MOD) begin
                  sum = sum - COUNT_MOD;
               end
               prefix[j] = sum[COUNT_WIDTH-1:0];
            end
         end
         if (eol) begin
            owed_counts.push_back(prefix[PATTERN_LEN-1]);
            foreach (prefix[j]) prefix[j] = '0;
         end
      endfunction

      function void check_count(input bit [COUNT_WIDTH-1:0] actual);
         bit [COUNT_WIDTH-1:0] wanted;
         if (owed_counts.size() == 0) begin
            $display("%0t: unexpected count word, expected none, actual %0d", $time, actual);
            mismatches++;
            return;
         end
         wanted = owed_counts.pop_front();
         counts_checked++;
         if (actual != 0) begin
            nonzero_counts++;
         end
         if (actual !== wanted) begin
            $display("%0t: occurrence_count mismatch, expected %0d, actual %0d",
                     $time, wanted, actual);
            mismatches++;
         end
      endfunction
   endclass

   line_count_board count_board = new();

   pattern_subsequence_counter_core #(
      .PATTERN_LENGTH(PATTERN_LEN)
   ) dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_character       (req_character),
      .req_end_of_line     (req_end_of_line),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_occurrence_count(rsp_occurrence_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // hard stop in case the block hangs
   initial begin
      #5000000;
      $display("Regression FAIL");
      $finish;
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         count_board.check_count(rsp_occurrence_count);
      end
   end

   // receiver back-pressure in random bursts
   initial begin
      forever begin
         @(posedge clock);
         if (idle_level != 0 && $urandom_range(0, 7) < idle_level) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // one character word, with an optional idle burst ahead of it
   task automatic send_character(input bit [CHAR_WIDTH-1:0] ch, input bit eol);
      if (idle_level != 0 && $urandom_range(0, 7) < idle_level) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_character   <= ch;
      req_end_of_line <= eol;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      count_board.note_character(ch, eol);
      chars_sent++;
   endtask

   task automatic send_line();
      foreach (line_bytes[i]) begin
         send_character(line_bytes[i], i == line_bytes.size() - 1);
      end
      lines_sent++;
   endtask

   initial begin
      int kind;
      int walks;
      int reps;
      int len;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: whole pattern once, then one-word lines 00, FF, first and last letter
      line_bytes.delete();
      for (int j = 0; j < PATTERN_LEN; j++) line_bytes.push_back(letter_at(j));
      send_line();
      line_bytes = '{8'h00};
      send_line();
      line_bytes = '{8'hFF};
      send_line();
      line_bytes = '{letter_at(0)};
      send_line();
      line_bytes = '{letter_at(PATTERN_LEN-1)};
      send_line();

      // random lines, mostly walks through the pattern with repeated letters
      while (chars_sent < TARGET_CHARS) begin
         line_bytes.delete();
         idle_level = (chars_sent >= CALM_FROM) ? 0 : $urandom_range(0, 3);
         kind = $urandom_range(0, 99);
         if (kind < 65) begin
            walks = ($urandom_range(0, 3) == 0) ? 2 : 1;
            repeat (walks) begin
               for (int j = 0; j < PATTERN_LEN; j++) begin
                  if ($urandom_range(0, 19) == 0) begin
                     line_bytes.push_back(CHAR_WIDTH'($urandom_range(0, 255)));
                  end
                  // an occasional skipped letter breaks the walk
                  reps = ($urandom_range(0, 14) == 0) ? 0 : $urandom_range(1, 3);
                  repeat (reps) line_bytes.push_back(letter_at(j));
               end
            end
         end else if (kind < 85) begin
            len = $urandom_range(1, 40);
            repeat (len) line_bytes.push_back(letter_at($urandom_range(0, PATTERN_LEN-1)));
         end else begin
            len = $urandom_range(1, 12);
            repeat (len) line_bytes.push_back(CHAR_WIDTH'($urandom_range(0, 255)));
         end
         if (line_bytes.size() == 0) begin
            line_bytes.push_back(CHAR_WIDTH'($urandom_range(0, 255)));
         end
         send_line();
      end
      req_valid <= 1'b0;
      idle_level = 0;

      // drain, then allow for the block's latency
      while (count_board.owed_counts.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Fed %0d characters in %0d lines; checked %0d line counts, %0d of them nonzero.",
               chars_sent, lines_sent, count_board.counts_checked, count_board.nonzero_counts);
      if (count_board.mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
